// File: design/xmbs_pkg.sv
// Package for the XMODEM-1K block sender: sizes, protocol characters, codes,
// the result beat type and the byte-wide CRC-16 update.
// Depends on nothing.
package xmbs_pkg;

  localparam int unsigned BlockBytes = 1024;
  localparam int unsigned AddrW      = $clog2(BlockBytes);
  localparam int unsigned CountW     = AddrW + 1;
  localparam int unsigned PosW       = $clog2(BlockBytes + 5);

  typedef logic [AddrW-1:0]  addr_t;
  typedef logic [CountW-1:0] count_t;
  typedef logic [PosW-1:0]   pos_t;

  localparam logic [7:0] ChSoh = 8'h01;
  localparam logic [7:0] ChStx = 8'h02;
  localparam logic [7:0] ChEot = 8'h04;
  localparam logic [7:0] ChAck = 8'h06;
  localparam logic [7:0] ChNak = 8'h15;
  localparam logic [7:0] ChCan = 8'h18;
  localparam logic [7:0] ChPad = 8'h1A;
  localparam logic [7:0] ChStart = (BlockBytes > 128) ? ChStx : ChSoh;

  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [7:0]  RetryLimitReset = 8'd20;

  localparam logic [1:0] KindLoad  = 2'd0;
  localparam logic [1:0] KindSlot  = 2'd1;
  localparam logic [1:0] KindReply = 2'd2;

  localparam logic OutByte   = 1'b0;
  localparam logic OutStatus = 1'b1;

  localparam logic [1:0] StDone       = 2'd0;
  localparam logic [1:0] StAborted    = 2'd1;
  localparam logic [1:0] StUnexpected = 2'd2;
  localparam logic [1:0] StNoEotAck   = 2'd3;

  typedef struct packed {
    logic       out_kind;
    logic [7:0] tx_byte;
    logic [1:0] status;
  } result_t;

  function automatic logic [15:0] crc_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

endpackage

// File: design/xmbs_item_if.sv
// Input channel of the block sender: valid, ready and one input beat.
// Depends on nothing.
interface xmbs_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;
  logic       last_of_image;

  modport source (output valid, kind, data_byte, last_of_image, input ready);
  modport sink (input valid, kind, data_byte, last_of_image, output ready);
endinterface

// File: design/xmbs_result_if.sv
// Output channel of the block sender: valid, ready and one result beat.
// Depends on nothing.
interface xmbs_result_if;
  logic       valid;
  logic       ready;
  logic       out_kind;
  logic [7:0] tx_byte;
  logic [1:0] status;

  modport source (output valid, out_kind, tx_byte, status, input ready);
  modport sink (input valid, out_kind, tx_byte, status, output ready);
endinterface

// File: design/xmbs_store.sv
// Block store: one write port and one read port with registered read data.
// Depends on xmbs_pkg.
module xmbs_store (
  input  logic           clk_i,
  input  logic           we_i,
  input  xmbs_pkg::addr_t waddr_i,
  input  logic [7:0]     wdata_i,
  input  xmbs_pkg::addr_t raddr_i,
  output logic [7:0]     rdata_o
);

  logic [7:0] mem [xmbs_pkg::BlockBytes];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: design/xmbs_outbuf.sv
// Output register with a skid stage, so the sender keeps taking beats while a
// result waits. Depends on xmbs_pkg and xmbs_result_if.
module xmbs_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  xmbs_pkg::result_t push_data_i,
  output logic              space_o,
  xmbs_result_if.source     result_o
);

  logic              head_valid_q, head_valid_d;
  logic              skid_valid_q, skid_valid_d;
  xmbs_pkg::result_t head_q, head_d;
  xmbs_pkg::result_t skid_q, skid_d;
  logic              pop;

  assign pop = head_valid_q & result_o.ready;

  always_comb begin
    head_valid_d = head_valid_q;
    skid_valid_d = skid_valid_q;
    head_d       = head_q;
    skid_d       = skid_q;
    if (pop || !head_valid_q) begin
      if (skid_valid_q) begin
        head_d       = skid_q;
        head_valid_d = 1'b1;
        skid_d       = push_data_i;
        skid_valid_d = push_i;
      end else begin
        head_d       = push_data_i;
        head_valid_d = push_i;
      end
    end else if (push_i) begin
      skid_d       = push_data_i;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      head_valid_q <= head_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign space_o           = !skid_valid_q;
  assign result_o.valid    = head_valid_q;
  assign result_o.out_kind = head_q.out_kind;
  assign result_o.tx_byte  = head_q.tx_byte;
  assign result_o.status   = head_q.status;

endmodule

// File: design/xmbs_top_ctrl_dummy_placeholder.sv
// Frame position decode for the block sender: which byte of the frame a
// position names, and whether its store index holds a loaded byte. Depends on xmbs_pkg.
module xmbs_frame_dec (
  input  xmbs_pkg::pos_t   pos_i,
  input  xmbs_pkg::count_t fill_i,
  output logic             is_start_o,
  output logic             is_num_o,
  output logic             is_cpl_o,
  output logic             is_data_o,
  output logic             is_crc_hi_o,
  output logic             data_valid_o
);

  localparam xmbs_pkg::pos_t PosData  = xmbs_pkg::pos_t'(3);
  localparam xmbs_pkg::pos_t PosCrcHi = xmbs_pkg::pos_t'(3 + xmbs_pkg::BlockBytes);

  xmbs_pkg::pos_t idx;

  assign idx          = pos_i - PosData;
  assign is_start_o   = (pos_i == xmbs_pkg::pos_t'(0));
  assign is_num_o     = (pos_i == xmbs_pkg::pos_t'(1));
  assign is_cpl_o     = (pos_i == xmbs_pkg::pos_t'(2));
  assign is_data_o    = (pos_i >= PosData) && (pos_i < PosCrcHi);
  assign is_crc_hi_o  = (pos_i == PosCrcHi);
  assign data_valid_o = (idx < xmbs_pkg::pos_t'(fill_i));

endmodule

// File: design/xmodem_1k_block_sender.sv
// XMODEM-1K block sender: loads image bytes, frames each block with CRC-16,
// and handles the receiver's replies. Depends on xmbs_pkg, the two channel
// interfaces, xmbs_store, xmbs_outbuf and xmbs_frame_dec.
//
//   channel    dir  beat                                  handshake
//   item_i     in   kind, data_byte, last_of_image        valid/ready
//   result_o   out  out_kind, tx_byte, status             valid/ready
//   cfg        in   cfg_data_i (retry_limit)              cfg_we_i
//
// Every beat is handled in the cycle it is accepted; one beat per cycle while item_i.ready is high.
// A result is registered in the output head register, or in the skid register while result_o stalls.
// Store reads are addressed from the next frame position, so the registered read data matches it.
// item_i.ready drops only while both output registers hold results.
// Reset is asynchronous and active low; the block store is not cleared.
module xmodem_1k_block_sender (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [7:0]    cfg_data_i,
  xmbs_item_if.sink     item_i,
  xmbs_result_if.source result_o
);

  localparam logic [2:0] PhLoading   = 3'd0;
  localparam logic [2:0] PhSending   = 3'd1;
  localparam logic [2:0] PhWaitReply = 3'd2;
  localparam logic [2:0] PhSendEot   = 3'd3;
  localparam logic [2:0] PhWaitEot   = 3'd4;
  localparam logic [2:0] PhSendCan   = 3'd5;
  localparam logic [2:0] PhFinished  = 3'd6;

  localparam xmbs_pkg::pos_t   PosData = xmbs_pkg::pos_t'(3);
  localparam xmbs_pkg::pos_t   PosEnd  = xmbs_pkg::pos_t'(5 + xmbs_pkg::BlockBytes);
  localparam xmbs_pkg::count_t FillMax = xmbs_pkg::count_t'(xmbs_pkg::BlockBytes);

  logic [2:0]        phase_q, phase_d;
  xmbs_pkg::count_t  fill_q, fill_d;
  xmbs_pkg::pos_t    pos_q, pos_d;
  logic [7:0]        block_num_q, block_num_d;
  logic [15:0]       crc_q, crc_d;
  logic [7:0]        retries_q, retries_d;
  logic              image_ended_q, image_ended_d;
  logic [7:0]        retry_limit_q;

  logic              accept;
  logic              space;
  logic              store_we;
  xmbs_pkg::addr_t   raddr;
  logic [7:0]        rdata;
  logic              res_valid;
  xmbs_pkg::result_t res;
  logic [7:0]        data_b;
  logic              is_start, is_num, is_cpl, is_data, is_crc_hi, data_valid;

  assign accept       = item_i.valid & item_i.ready;
  assign item_i.ready = space;

  xmbs_frame_dec u_dec (
    .pos_i        (pos_q),
    .fill_i       (fill_q),
    .is_start_o   (is_start),
    .is_num_o     (is_num),
    .is_cpl_o     (is_cpl),
    .is_data_o    (is_data),
    .is_crc_hi_o  (is_crc_hi),
    .data_valid_o (data_valid)
  );

  assign data_b = data_valid ? rdata : xmbs_pkg::ChPad;

  always_comb begin
    phase_d       = phase_q;
    fill_d        = fill_q;
    pos_d         = pos_q;
    block_num_d   = block_num_q;
    crc_d         = crc_q;
    retries_d     = retries_q;
    image_ended_d = image_ended_q;
    store_we      = 1'b0;
    res_valid     = 1'b0;
    res           = '{out_kind: xmbs_pkg::OutByte, tx_byte: 8'h00,
                      status: xmbs_pkg::StDone};
    if (accept) begin
      unique case (item_i.kind)
        xmbs_pkg::KindLoad: begin
          if (phase_q == PhLoading) begin
            store_we = 1'b1;
            fill_d   = fill_q + xmbs_pkg::count_t'(1);
            if (fill_d >= FillMax || item_i.last_of_image) begin
              image_ended_d = item_i.last_of_image;
              phase_d       = PhSending;
              pos_d         = '0;
              retries_d     = retry_limit_q;
            end
          end
        end
        xmbs_pkg::KindSlot: begin
          if (phase_q == PhSending) begin
            res_valid = 1'b1;
            if (is_start) begin
              res.tx_byte = xmbs_pkg::ChStart;
              crc_d       = 16'h0000;
            end else if (is_num) begin
              res.tx_byte = block_num_q;
            end else if (is_cpl) begin
              res.tx_byte = ~block_num_q;
            end else if (is_data) begin
              res.tx_byte = data_b;
              crc_d       = xmbs_pkg::crc_update(crc_q, data_b);
            end else if (is_crc_hi) begin
              res.tx_byte = crc_q[15:8];
            end else begin
              res.tx_byte = crc_q[7:0];
            end
            pos_d = pos_q + xmbs_pkg::pos_t'(1);
            if (pos_d >= PosEnd) begin
              pos_d   = '0;
              phase_d = PhWaitReply;
            end
          end else if (phase_q == PhSendEot) begin
            res_valid   = 1'b1;
            res.tx_byte = xmbs_pkg::ChEot;
            phase_d     = PhWaitEot;
          end else if (phase_q == PhSendCan) begin
            res_valid   = 1'b1;
            res.tx_byte = xmbs_pkg::ChCan;
            phase_d     = PhFinished;
          end
        end
        xmbs_pkg::KindReply: begin
          if (phase_q == PhWaitReply) begin
            if (item_i.data_byte == xmbs_pkg::ChAck) begin
              block_num_d = block_num_q + 8'd1;
              if (image_ended_q) begin
                phase_d = PhSendEot;
              end else begin
                phase_d = PhLoading;
                fill_d  = '0;
              end
            end else if (item_i.data_byte == xmbs_pkg::ChNak) begin
              if (retries_q != 8'd0) begin
                retries_d = retries_q - 8'd1;
                pos_d     = '0;
                phase_d   = PhSending;
              end else begin
                phase_d      = PhSendCan;
                res_valid    = 1'b1;
                res.out_kind = xmbs_pkg::OutStatus;
                res.status   = xmbs_pkg::StAborted;
              end
            end else begin
              phase_d      = PhSendCan;
              res_valid    = 1'b1;
              res.out_kind = xmbs_pkg::OutStatus;
              res.status   = xmbs_pkg::StUnexpected;
            end
          end else if (phase_q == PhWaitEot) begin
            phase_d      = PhFinished;
            res_valid    = 1'b1;
            res.out_kind = xmbs_pkg::OutStatus;
            res.status   = (item_i.data_byte == xmbs_pkg::ChAck) ?
                           xmbs_pkg::StDone : xmbs_pkg::StNoEotAck;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign raddr = (pos_d >= PosData) ? xmbs_pkg::addr_t'(pos_d - PosData) : '0;

  xmbs_store u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (xmbs_pkg::addr_t'(fill_q)),
    .wdata_i (item_i.data_byte),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  xmbs_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .result_o    (result_o)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PhLoading;
      fill_q        <= '0;
      pos_q         <= '0;
      block_num_q   <= 8'd1;
      crc_q         <= 16'h0000;
      retries_q     <= xmbs_pkg::RetryLimitReset;
      image_ended_q <= 1'b0;
      retry_limit_q <= xmbs_pkg::RetryLimitReset;
    end else begin
      phase_q       <= phase_d;
      fill_q        <= fill_d;
      pos_q         <= pos_d;
      block_num_q   <= block_num_d;
      crc_q         <= crc_d;
      retries_q     <= retries_d;
      image_ended_q <= image_ended_d;
      if (cfg_we_i) begin
        retry_limit_q <= cfg_data_i;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_finished_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PhFinished |-> !res_valid)
    else $error("result produced after the transfer finished");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FillMax)
    else $error("fill count beyond block size");

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PosEnd)
    else $error("frame position beyond frame end");

  a_byte_status_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid && res.out_kind == xmbs_pkg::OutByte |-> res.status == xmbs_pkg::StDone)
    else $error("byte beat carries a status");

  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != PhSending |-> pos_q == xmbs_pkg::pos_t'(0))
    else $error("frame position left over outside sending");

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !space |-> !res_valid)
    else $error("result pushed while output buffer full");
`endif

endmodule

// File: tb/sv/xmodem_1k_block_sender_tb.sv
// Testbench for xmodem_1k_block_sender: drives image bytes, transmit slots and
// replies over a one-block transfer with a resend and checks every result beat
// against a predictor held in a scoreboard class. Depends on xmbs_pkg and the interfaces.
module xmodem_1k_block_sender_tb;

  localparam logic [1:0] KindUnused   = 2'd3;
  localparam int         QuietLimit   = 2000;
  localparam int         HoldCycles   = 120;
  localparam int         SettleCycles = 6;
  localparam int         NoisePct     = 2;

  typedef enum logic [2:0] {
    PhLoading, PhSending, PhWaitReply, PhSendEot, PhWaitEot, PhSendCan, PhFinished
  } xfer_phase_e;

  class sender_scoreboard;
    logic [7:0]        store [xmbs_pkg::BlockBytes];
    xmbs_pkg::count_t  fill;
    xmbs_pkg::pos_t    pos;
    xfer_phase_e       phase;
    logic [7:0]        blk_num;
    logic [15:0]       crc;
    logic [7:0]        retries;
    logic [7:0]        limit;
    logic              ended;
    xmbs_pkg::result_t due_q[$];
    int                errors;
    int                beats_in;
    int                bytes_seen;
    int                status_seen;
    int                frames;

    function new();
      fill = '0;
      pos = '0;
      phase = PhLoading;
      blk_num = 8'd1;
      crc = '0;
      retries = xmbs_pkg::RetryLimitReset;
      limit = xmbs_pkg::RetryLimitReset;
      ended = 1'b0;
    endfunction

    function void set_limit(logic [7:0] v);
      limit = v;
    endfunction

    function logic [15:0] crc_step(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int k = 7; k >= 0; k--) begin
        fb = c[15] ^ b[k];
        c = {c[14:0], 1'b0};
        if (fb) c = c ^ xmbs_pkg::CrcPoly;
      end
      return c;
    endfunction

    function logic [7:0] frame_byte(xmbs_pkg::pos_t p);
      logic [7:0] b;
      int         i;
      if (p == 0) begin
        crc = '0;
        return xmbs_pkg::ChStart;
      end
      if (p == 1) return blk_num;
      if (p == 2) return ~blk_num;
      if (p < xmbs_pkg::BlockBytes + 3) begin
        i = int'(p) - 3;
        b = (i < fill) ? store[i] : xmbs_pkg::ChPad;
        crc = crc_step(crc, b);
        return b;
      end
      if (p == xmbs_pkg::BlockBytes + 3) return crc[15:8];
      return crc[7:0];
    endfunction

    function void push_byte(logic [7:0] b);
      due_q.push_back('{out_kind: xmbs_pkg::OutByte, tx_byte: b, status: 2'd0});
    endfunction

    function void push_status(logic [1:0] s);
      due_q.push_back('{out_kind: xmbs_pkg::OutStatus, tx_byte: 8'd0, status: s});
    endfunction

    function void note_item(logic [1:0] kind, logic [7:0] data, logic last);
      beats_in++;
      case (kind)
        xmbs_pkg::KindLoad: begin
          if (phase == PhLoading) begin
            store[fill[xmbs_pkg::AddrW-1:0]] = data;
            fill++;
            if (fill >= xmbs_pkg::BlockBytes || last) begin
              ended = last;
              phase = PhSending;
              pos = '0;
              retries = limit;
            end
          end
        end
        xmbs_pkg::KindSlot: begin
          case (phase)
            PhSending: begin
              push_byte(frame_byte(pos));
              pos++;
              if (pos >= xmbs_pkg::BlockBytes + 5) begin
                pos = '0;
                phase = PhWaitReply;
                frames++;
              end
            end
            PhSendEot: begin
              phase = PhWaitEot;
              push_byte(xmbs_pkg::ChEot);
            end
            PhSendCan: begin
              phase = PhFinished;
              push_byte(xmbs_pkg::ChCan);
            end
            default: ;
          endcase
        end
        xmbs_pkg::KindReply: begin
          if (phase == PhWaitReply) begin
            if (data == xmbs_pkg::ChAck) begin
              blk_num++;
              if (ended) begin
                phase = PhSendEot;
              end else begin
                phase = PhLoading;
                fill = '0;
              end
            end else if (data == xmbs_pkg::ChNak) begin
              if (retries > 0) begin
                retries--;
                pos = '0;
                phase = PhSending;
              end else begin
                phase = PhSendCan;
                push_status(xmbs_pkg::StAborted);
              end
            end else begin
              phase = PhSendCan;
              push_status(xmbs_pkg::StUnexpected);
            end
          end else if (phase == PhWaitEot) begin
            phase = PhFinished;
            push_status((data == xmbs_pkg::ChAck) ? xmbs_pkg::StDone : xmbs_pkg::StNoEotAck);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_result(xmbs_pkg::result_t got);
      xmbs_pkg::result_t want;
      if (due_q.size() == 0) begin
        $error("result beat with nothing expected: out_kind %0d tx_byte 0x%02h status %0d",
               got.out_kind, got.tx_byte, got.status);
        errors++;
        return;
      end
      want = due_q.pop_front();
      if (got.out_kind !== want.out_kind) begin
        $error("out_kind: expected %0d, got %0d", want.out_kind, got.out_kind);
        errors++;
      end
      if (got.tx_byte !== want.tx_byte) begin
        $error("tx_byte: expected 0x%02h, got 0x%02h", want.tx_byte, got.tx_byte);
        errors++;
      end
      if (got.status !== want.status) begin
        $error("status: expected %0d, got %0d", want.status, got.status);
        errors++;
      end
      if (want.out_kind == xmbs_pkg::OutByte) bytes_seen++;
      else status_seen++;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [7:0] cfg_data;

  xmbs_item_if   item_bus ();
  xmbs_result_if result_bus ();

  sender_scoreboard sb;
  int  src_idle_pct;
  int  sink_stall_pct;
  int  beats_sent;
  int  limit_writes;
  int  quiet;
  bit  hold_req;

  xmodem_1k_block_sender dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data),
    .item_i    (item_bus),
    .result_o  (result_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (item_bus.valid === 1'b1 && item_bus.ready === 1'b1) ||
        (result_bus.valid === 1'b1 && result_bus.ready === 1'b1)) begin
      quiet <= 0;
    end else if (quiet >= QuietLimit) begin
      $display("xmodem_1k_block_sender_tb: FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    result_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (result_bus.valid === 1'b1 && result_bus.ready === 1'b1) begin
        sb.check_result('{out_kind: result_bus.out_kind, tx_byte: result_bus.tx_byte,
                          status: result_bus.status});
      end
      if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HoldCycles;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_bus.ready <= 1'b0;
      end else begin
        result_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  function automatic bit phase_ignores(logic [1:0] k, xfer_phase_e ph);
    case (k)
      xmbs_pkg::KindLoad:  return ph != PhLoading;
      xmbs_pkg::KindSlot:  return !(ph == PhSending || ph == PhSendEot || ph == PhSendCan);
      xmbs_pkg::KindReply: return !(ph == PhWaitReply || ph == PhWaitEot);
      default:             return 1'b1;
    endcase
  endfunction

  task automatic push_item(logic [1:0] k, logic [7:0] d, logic last);
    if (beats_sent % 256 == 0) begin
      case ((beats_sent / 256) % 4)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 59; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 59; end
        default: begin src_idle_pct = 30; sink_stall_pct = 30; end
      endcase
    end
    while ($urandom_range(99) < src_idle_pct) begin
      item_bus.valid <= 1'b0;
      @(posedge clk);
    end
    item_bus.valid <= 1'b1;
    item_bus.kind <= k;
    item_bus.data_byte <= d;
    item_bus.last_of_image <= last;
    @(posedge clk);
    while (item_bus.ready !== 1'b1) @(posedge clk);
    sb.note_item(k, d, last);
    beats_sent++;
  endtask

  // Now and then an ignored beat goes ahead of the real one.
  task automatic offer(logic [1:0] k, logic [7:0] d, logic last);
    logic [1:0] nk;
    if ($urandom_range(99) < NoisePct) begin
      nk = 2'($urandom_range(0, 3));
      if (!phase_ignores(nk, sb.phase)) nk = KindUnused;
      push_item(nk, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
    push_item(k, d, last);
  endtask

  task automatic settle();
    item_bus.valid <= 1'b0;
    while (sb.due_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_limit(logic [7:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    sb.set_limit(v);
    cfg_we <= 1'b0;
    limit_writes++;
  endtask

  task automatic load_block(int n, logic last);
    for (int i = 0; i < n; i++) begin
      offer(xmbs_pkg::KindLoad, 8'($urandom_range(0, 255)), last && (i == n - 1));
    end
  endtask

  task automatic send_frame(int hold_at, int pause_at);
    while (sb.phase == PhSending) begin
      if (sb.pos == hold_at) hold_req = 1'b1;
      if (sb.pos == pause_at) settle();
      offer(xmbs_pkg::KindSlot, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    end
  endtask

  initial begin : stimulus
    logic [7:0] b;
    logic [1:0] ending;
    int         n;
    logic [7:0] first_bytes [8];
    sb = new();
    first_bytes = '{8'h00, 8'hFF, xmbs_pkg::ChPad, 8'h80, 8'h01, xmbs_pkg::ChAck,
                    xmbs_pkg::ChNak, 8'h7F};
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_data <= '0;
    item_bus.valid <= 1'b0;
    item_bus.kind <= xmbs_pkg::KindLoad;
    item_bus.data_byte <= '0;
    item_bus.last_of_image <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    ending = 2'($urandom_range(0, 3));

    // Beats that the loading phase must ignore, then a short padded block.
    push_item(xmbs_pkg::KindSlot, 8'hFF, 1'b1);
    push_item(xmbs_pkg::KindReply, xmbs_pkg::ChAck, 1'b0);
    push_item(xmbs_pkg::KindReply, xmbs_pkg::ChNak, 1'b1);
    push_item(KindUnused, 8'h00, 1'b1);
    write_limit(8'd1);
    foreach (first_bytes[i]) push_item(xmbs_pkg::KindLoad, first_bytes[i], 1'b0);
    case ($urandom_range(0, 1))
      0: n = 1;
      default: n = int'($urandom_range(2, 32));
    endcase
    load_block(n, 1'b1);
    send_frame(300, -1);

    // A limit written while a reply is awaited must not change the current block.
    write_limit(8'd0);
    offer(xmbs_pkg::KindReply, xmbs_pkg::ChNak, 1'b1);
    send_frame(-1, 600);

    case (ending)
      xmbs_pkg::StAborted: begin
        offer(xmbs_pkg::KindReply, xmbs_pkg::ChNak, 1'b0);
        offer(xmbs_pkg::KindSlot, 8'h00, 1'b0);
      end
      xmbs_pkg::StUnexpected: begin
        do b = 8'($urandom_range(0, 255));
        while (b == xmbs_pkg::ChAck || b == xmbs_pkg::ChNak);
        offer(xmbs_pkg::KindReply, b, 1'b1);
        offer(xmbs_pkg::KindSlot, 8'h00, 1'b0);
      end
      default: begin
        offer(xmbs_pkg::KindReply, xmbs_pkg::ChAck, 1'b0);
        offer(xmbs_pkg::KindSlot, 8'h00, 1'b1);
        if (ending == xmbs_pkg::StDone) begin
          b = xmbs_pkg::ChAck;
        end else begin
          do b = 8'($urandom_range(0, 255)); while (b == xmbs_pkg::ChAck);
        end
        offer(xmbs_pkg::KindReply, b, 1'b0);
      end
    endcase

    // Once the transfer has finished, every beat must be ignored.
    repeat (8) begin
      push_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                1'($urandom_range(0, 1)));
    end
    settle();

    $display("Run covered %0d input beats over %0d frames with %0d retry-limit writes;",
             sb.beats_in, sb.frames, limit_writes);
    $display("checked %0d transmit bytes and %0d status beat(s), final status code %0d.",
             sb.bytes_seen, sb.status_seen, ending);
    if (sb.errors == 0 && sb.due_q.size() == 0) begin
      $display("xmodem_1k_block_sender_tb: PASS");
    end else begin
      $display("xmodem_1k_block_sender_tb: FAIL");
    end
    $finish;
  end

endmodule
